### src/kks_pkg.sv
// shared types and constants for the keyed key store
// no dependencies
`timescale 1ns / 1ps

package kks_pkg;

  typedef enum logic [2:0] {
    MODE_RECORD = 3'd0,
    MODE_LOOKUP = 3'd1,
    MODE_FORGET = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_CLEAN  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_DECIDE,
    ST_KEY_RD,
    ST_KEY_CMP,
    ST_KEY_WR,
    ST_LKP_RD,
    ST_LKP_OUT,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DONE
  } state_t;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned SEQ_W  = 32;

endpackage

### src/keyed_key_store_lru_unit.sv
// keyed key store with least-recently-used replacement, top level
// uses kks_pkg; id/stamp memory and key memory live here
`timescale 1ns / 1ps

// channel | ports                                          | direction
// input   | start, in_mode/node_id/key_word/word_index     | in; busy is out
// result  | out_valid, out_ok/key_word_res/last/entry_count/dirty | out
//
// a record word that does not commit, a clear, a clean or any other mode goes straight to
// the done state; lookups, forgets and commits read the entry memory one slot a cycle,
// then handle key words: a commit reads and compares each word, then writes them; a lookup
// reads and outputs each word; a forget moves the last entry's words into the freed slot.
// reset is synchronous and empties the table; no clearing pass is needed.
// results are strobed by out_valid for one cycle each and cannot be stalled.

module keyed_key_store_lru_unit #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WORDS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_mode,
  input  logic [kks_pkg::ID_W-1:0]    in_node_id,
  input  logic [kks_pkg::WORD_W-1:0]  in_key_word,
  input  logic [1:0]                  in_word_index,
  output logic                        out_valid,
  output logic                        out_ok,
  output logic [kks_pkg::WORD_W-1:0]  out_key_word_res,
  output logic                        out_last,
  output logic [4:0]                  out_entry_count,
  output logic                        out_dirty
);

  localparam int unsigned SW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned WW  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int unsigned KD  = CAPACITY * KEY_WORDS;
  localparam int unsigned KAW = (KD > 1) ? $clog2(KD) : 1;
  localparam int unsigned EW  = kks_pkg::ID_W + kks_pkg::SEQ_W;

  // entry memory: {id, stamp}; key memory: slot*KEY_WORDS+word
  logic [EW-1:0]             ent_mem [CAPACITY];
  logic [kks_pkg::WORD_W-1:0] key_mem [KD];
  logic [kks_pkg::WORD_W-1:0] staging_r [KEY_WORDS];

  kks_pkg::state_t state_r, state_nxt;

  logic [2:0]                 mode_r;
  logic [kks_pkg::ID_W-1:0]   id_r;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic [kks_pkg::SEQ_W-1:0]  seq_r;
  logic                       changed_r;
  logic [SW-1:0]              scan_r;      // slot whose read data arrives next
  logic                       hit_r;
  logic [SW-1:0]              hit_slot_r;
  logic [SW-1:0]              old_slot_r;
  logic [kks_pkg::SEQ_W-1:0]  old_stamp_r;
  logic [SW-1:0]              tgt_r;
  logic [WW-1:0]              wcnt_r;
  logic                       diff_r;
  logic                       newent_r;
  logic                       ok_r;

  logic [EW-1:0]              ent_q;
  logic [kks_pkg::WORD_W-1:0] key_q;

  // memory ports
  logic [SW-1:0]              ent_ra;
  logic                       ent_we;
  logic [SW-1:0]              ent_wa;
  logic [EW-1:0]              ent_wd;
  logic [KAW-1:0]             key_ra;
  logic                       key_we;
  logic [KAW-1:0]             key_wa;
  logic [kks_pkg::WORD_W-1:0] key_wd;

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_q <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_q <= key_mem[key_ra];
  end

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != kks_pkg::ST_IDLE);

  logic commit_now;
  assign commit_now = (in_mode == kks_pkg::MODE_RECORD) &&
                      ({30'd0, in_word_index} == KEY_WORDS - 1) && (in_node_id != '0);

  logic [kks_pkg::ID_W-1:0] ent_id;
  logic [kks_pkg::SEQ_W-1:0] ent_stamp;
  assign ent_id    = ent_q[EW-1:kks_pkg::SEQ_W];
  assign ent_stamp = ent_q[kks_pkg::SEQ_W-1:0];

  // the slot in ent_q is the last valid one
  logic scan_last;
  assign scan_last = (SW'(scan_r - 1'b1) == SW'(count_r - 1'b1));

  logic [KAW-1:0] key_addr_tgt;
  logic [KAW-1:0] key_addr_src;
  assign key_addr_tgt = KAW'(tgt_r * KEY_WORDS + wcnt_r);
  assign key_addr_src = KAW'((count_r - 1'b1) * KEY_WORDS + wcnt_r);

  logic wlast;
  assign wlast = ({{(32-WW){1'b0}}, wcnt_r} == KEY_WORDS - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kks_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == kks_pkg::MODE_LOOKUP || in_mode == kks_pkg::MODE_FORGET ||
              commit_now) begin
            state_nxt = (count_r == '0) ? kks_pkg::ST_DECIDE : kks_pkg::ST_SCAN_RD;
          end else begin
            state_nxt = kks_pkg::ST_DONE;
          end
        end
      end
      kks_pkg::ST_SCAN_RD: state_nxt = kks_pkg::ST_SCAN;
      kks_pkg::ST_SCAN: if (scan_last) state_nxt = kks_pkg::ST_DECIDE;
      kks_pkg::ST_DECIDE: begin
        case (mode_r)
          kks_pkg::MODE_RECORD: state_nxt = kks_pkg::ST_KEY_RD;
          kks_pkg::MODE_LOOKUP:
            state_nxt = (hit_r && id_r != '0) ? kks_pkg::ST_LKP_RD : kks_pkg::ST_DONE;
          kks_pkg::MODE_FORGET:
            state_nxt = (hit_r && {{(32-SW){1'b0}}, hit_slot_r} + 32'd1 <
                         {{(32-CW){1'b0}}, count_r}) ? kks_pkg::ST_MOVE_RD :
                        kks_pkg::ST_DONE;
          default: state_nxt = kks_pkg::ST_DONE;
        endcase
      end
      kks_pkg::ST_KEY_RD: state_nxt = kks_pkg::ST_KEY_CMP;
      kks_pkg::ST_KEY_CMP: state_nxt = wlast ? kks_pkg::ST_KEY_WR : kks_pkg::ST_KEY_RD;
      kks_pkg::ST_KEY_WR: if (wlast) state_nxt = kks_pkg::ST_DONE;
      kks_pkg::ST_LKP_RD: state_nxt = kks_pkg::ST_LKP_OUT;
      kks_pkg::ST_LKP_OUT: state_nxt = wlast ? kks_pkg::ST_IDLE : kks_pkg::ST_LKP_RD;
      kks_pkg::ST_MOVE_RD: state_nxt = kks_pkg::ST_MOVE_WR;
      kks_pkg::ST_MOVE_WR: if (wlast) state_nxt = kks_pkg::ST_DONE;
      kks_pkg::ST_DONE: state_nxt = kks_pkg::ST_IDLE;
      default: state_nxt = kks_pkg::ST_IDLE;
    endcase
  end

  // memory control and result outputs
  always_comb begin
    ent_ra = scan_r;
    ent_we = 1'b0;
    ent_wa = tgt_r;
    ent_wd = {id_r, seq_r};
    key_ra = key_addr_tgt;
    key_we = 1'b0;
    key_wa = key_addr_tgt;
    key_wd = staging_r[wcnt_r];
    out_valid        = 1'b0;
    out_ok           = ok_r;
    out_key_word_res = '0;
    out_last         = 1'b1;
    out_entry_count  = 5'(count_nxt);
    out_dirty        = changed_r;
    case (state_r)
      kks_pkg::ST_IDLE: ent_ra = '0;
      kks_pkg::ST_MOVE_RD: begin
        ent_ra = SW'(count_r - 1'b1);
        key_ra = key_addr_src;
      end
      kks_pkg::ST_MOVE_WR: begin
        key_we = 1'b1;
        key_wd = key_q;
        key_ra = KAW'(key_addr_src + 1'b1);
        ent_we = (wcnt_r == '0);
        ent_wd = ent_q;
      end
      kks_pkg::ST_KEY_WR: begin
        key_we = diff_r || newent_r;
        ent_we = (wcnt_r == '0);
      end
      kks_pkg::ST_LKP_OUT: begin
        out_valid        = 1'b1;
        out_ok           = 1'b1;
        out_key_word_res = key_q;
        out_last         = wlast;
        ent_we           = (wcnt_r == '0);
        ent_wa           = hit_slot_r;
        ent_wd           = {id_r, seq_r};
      end
      kks_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (state_r == kks_pkg::ST_DECIDE && mode_r == kks_pkg::MODE_RECORD && !hit_r &&
        {{(32-CW){1'b0}}, count_r} < CAPACITY)
      count_nxt = count_r + 1'b1;
    if (state_r == kks_pkg::ST_DONE && mode_r == kks_pkg::MODE_FORGET && ok_r)
      count_nxt = count_r - 1'b1;
    if (state_r == kks_pkg::ST_DONE && mode_r == kks_pkg::MODE_CLEAR)
      count_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kks_pkg::ST_IDLE;
      count_r   <= '0;
      seq_r     <= '0;
      changed_r <= 1'b0;
      ok_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        kks_pkg::ST_IDLE: if (accept) begin
          mode_r  <= in_mode;
          id_r    <= in_node_id;
          scan_r  <= '0;
          hit_r   <= 1'b0;
          wcnt_r  <= '0;
          diff_r  <= 1'b0;
          old_slot_r <= '0;
          ok_r    <= 1'b0;
          case (in_mode)
            kks_pkg::MODE_RECORD: begin
              if ({30'd0, in_word_index} < KEY_WORDS) begin
                staging_r[WW'(in_word_index)] <= in_key_word;
                ok_r <= ({30'd0, in_word_index} != KEY_WORDS - 1) || (in_node_id != '0);
              end
            end
            kks_pkg::MODE_CLEAR: begin
              ok_r <= 1'b1;
              seq_r <= '0;
              changed_r <= 1'b0;
            end
            kks_pkg::MODE_CLEAN: begin
              ok_r <= 1'b1;
              changed_r <= 1'b0;
            end
            default: ;
          endcase
        end
        kks_pkg::ST_SCAN_RD: scan_r <= SW'(scan_r + 1'b1);
        kks_pkg::ST_SCAN: begin
          // ent_q holds slot scan_r-1 (first pass slot 0)
          if (!hit_r && ent_id == id_r) begin
            hit_r      <= 1'b1;
            hit_slot_r <= SW'(scan_r - 1'b1);
          end
          if (scan_r == SW'(1) || ent_stamp < old_stamp_r) begin
            old_stamp_r <= ent_stamp;
            old_slot_r  <= SW'(scan_r - 1'b1);
          end
          scan_r <= SW'(scan_r + 1'b1);
        end
        kks_pkg::ST_DECIDE: begin
          newent_r <= !hit_r;
          if (hit_r) tgt_r <= hit_slot_r;
          else if ({{(32-CW){1'b0}}, count_r} < CAPACITY) tgt_r <= SW'(count_r);
          else tgt_r <= old_slot_r;
          if (mode_r == kks_pkg::MODE_RECORD ||
              (mode_r == kks_pkg::MODE_LOOKUP && hit_r && id_r != '0))
            seq_r <= seq_r + 1'b1;
          if (mode_r == kks_pkg::MODE_RECORD && !hit_r) changed_r <= 1'b1;
          if (mode_r == kks_pkg::MODE_FORGET && hit_r) begin
            changed_r <= 1'b1;
            ok_r <= 1'b1;
            tgt_r <= hit_slot_r;
          end
        end
        kks_pkg::ST_KEY_CMP: begin
          if (key_q != staging_r[wcnt_r]) diff_r <= 1'b1;
          wcnt_r <= wlast ? '0 : WW'(wcnt_r + 1'b1);
        end
        kks_pkg::ST_KEY_WR: begin
          if (diff_r) changed_r <= 1'b1;
          wcnt_r <= WW'(wcnt_r + 1'b1);
        end
        kks_pkg::ST_LKP_OUT: wcnt_r <= WW'(wcnt_r + 1'b1);
        kks_pkg::ST_MOVE_WR: wcnt_r <= WW'(wcnt_r + 1'b1);
        default: ;
      endcase
      count_r <= count_nxt;
    end
  end

endmodule

### src/kks_checker.sv
// port-level checks for the keyed key store
// bound to keyed_key_store_lru_unit
`timescale 1ns / 1ps

module kks_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_ok,
  input logic [63:0] out_key_word_res,
  input logic       out_last,
  input logic [4:0] out_entry_count,
  input logic       out_dirty
);

  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");
  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid) else $error("result while idle");
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok && out_entry_count == 5'd0 && out_key_word_res != '0 |-> 1'b0)
    else $error("key word with empty table");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_last && out_key_word_res == '0)
    else $error("refused transaction malformed");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 5'd16) else $error("count out of range");

endmodule

bind keyed_key_store_lru_unit kks_checker u_kks_checker (.*);
